@@ rtl/mrcp_pkg.sv @@
// Types and constants shared by the modem reply and command parser.
// No dependencies.
`default_nettype none
package mrcp_pkg;

  typedef enum logic [4:0] {
    R_IDLE = 5'd0,
    R_O    = 5'd1,
    R_GT   = 5'd2,
    R_CR   = 5'd3,
    R_LF   = 5'd4,
    R_E1   = 5'd5,
    R_E2   = 5'd6,
    R_E3   = 5'd7,
    R_E4   = 5'd8,
    R_S    = 5'd9,
    R_ST1  = 5'd10,
    R_ST2  = 5'd11,
    R_ST3  = 5'd12,
    R_ST4  = 5'd13,
    R_ST5  = 5'd14,
    R_R    = 5'd15,
    R_RD   = 5'd16,
    R_SE   = 5'd17,
    R_C1   = 5'd18,
    R_C2   = 5'd19,
    R_C3   = 5'd20,
    R_C4   = 5'd21,
    R_U1   = 5'd22,
    R_U2   = 5'd23,
    R_U3   = 5'd24,
    R_U4   = 5'd25,
    R_U5   = 5'd26
  } reply_state_t;

  typedef enum logic [1:0] {
    N_IDLE   = 2'd0,
    N_PLUS   = 2'd1,
    N_DIGITS = 2'd2
  } number_state_t;

  typedef enum logic [1:0] {
    CODE_OK     = 2'd0,
    CODE_READY  = 2'd1,
    CODE_ERROR  = 2'd2,
    CODE_UNREAD = 2'd3
  } resp_code_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic       response_valid;
    resp_code_t response_code;
    logic       status_request;
    logic [7:0] digital_out;
    logic       port_touched;
    logic       unread_seen;
  } reply_res_t;

  typedef struct packed {
    logic       number_write;
    logic [4:0] number_index;
    logic [7:0] number_char;
    logic       number_done;
    logic       number_cleared;
  } number_res_t;

endpackage
`default_nettype wire

@@ rtl/mrcp_if.sv @@
// Valid/ready channel interfaces for the parser's input bytes and results.
// No dependencies.
`default_nettype none
interface mrcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrcp_out_if;
  logic       valid;
  logic       ready;
  logic       response_valid;
  logic [1:0] response_code;
  logic       status_request;
  logic [7:0] digital_out;
  logic       port_touched;
  logic       unread_seen;
  logic       number_write;
  logic [4:0] number_index;
  logic [7:0] number_char;
  logic       number_done;
  logic       number_cleared;
  modport source (output valid, output response_valid, output response_code,
                  output status_request, output digital_out, output port_touched,
                  output unread_seen, output number_write, output number_index,
                  output number_char, output number_done, output number_cleared,
                  input ready);
  modport sink   (input valid, input response_valid, input response_code,
                  input status_request, input digital_out, input port_touched,
                  input unread_seen, input number_write, input number_index,
                  input number_char, input number_done, input number_cleared,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/mrcp_reply.sv @@
// Reply and command token matcher with mode flags and the output bit register.
// Depends on mrcp_pkg.
`default_nettype none
module mrcp_reply
  import mrcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output reply_res_t      res
);

  reply_state_t state_r, state_nxt;
  resp_code_t   pend_r, pend_nxt;
  logic         set_r, set_nxt;
  logic         clr_r, clr_nxt;
  logic [7:0]   bits_r, bits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      pend_r  <= CODE_OK;
      set_r   <= 1'b0;
      clr_r   <= 1'b0;
      bits_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      set_r   <= set_nxt;
      clr_r   <= clr_nxt;
      bits_r  <= bits_nxt;
    end
  end

  always_comb begin
    logic [7:0] mask;
    mask      = 8'd1 << rx_byte[2:0];
    state_nxt = R_IDLE;
    pend_nxt  = pend_r;
    set_nxt   = set_r;
    clr_nxt   = clr_r;
    bits_nxt  = bits_r;
    res       = '0;
    case (state_r)
      R_IDLE: begin
        pend_nxt = CODE_OK;
        case (rx_byte)
          "O":     state_nxt = R_O;
          ">":     state_nxt = R_GT;
          "E":     state_nxt = R_E1;
          "S":     state_nxt = R_S;
          "R":     state_nxt = R_R;
          "C":     state_nxt = R_C1;
          "U":     state_nxt = R_U1;
          default: state_nxt = R_IDLE;
        endcase
      end
      R_O: begin
        if (rx_byte == "K") begin
          pend_nxt  = CODE_OK;
          state_nxt = R_CR;
        end
      end
      R_GT: begin
        if (rx_byte == " ") begin
          pend_nxt = CODE_READY;
          res.response_valid = 1'b1;
          res.response_code  = CODE_READY;
        end
      end
      R_CR:  if (rx_byte == CH_CR) state_nxt = R_LF;
      R_LF: begin
        if (rx_byte == CH_LF) begin
          res.response_valid = 1'b1;
          res.response_code  = pend_r;
        end
      end
      R_E1:  if (rx_byte == "R") state_nxt = R_E2;
      R_E2:  if (rx_byte == "R") state_nxt = R_E3;
      R_E3:  if (rx_byte == "O") state_nxt = R_E4;
      R_E4: begin
        if (rx_byte == "R") begin
          pend_nxt = CODE_ERROR;
          res.response_valid = 1'b1;
          res.response_code  = CODE_ERROR;
        end
      end
      R_S: begin
        if (rx_byte == "t") state_nxt = R_ST1;
        else if (rx_byte == "e") state_nxt = R_SE;
      end
      R_ST1: if (rx_byte == "a") state_nxt = R_ST2;
      R_ST2: if (rx_byte == "t") state_nxt = R_ST3;
      R_ST3: if (rx_byte == "u") state_nxt = R_ST4;
      R_ST4: if (rx_byte == "s") state_nxt = R_ST5;
      R_ST5: res.status_request = (rx_byte == "?");
      R_R:   if (rx_byte == "D") state_nxt = R_RD;
      R_RD: begin
        if (rx_byte >= "0" && rx_byte <= "7") begin
          if (set_r) bits_nxt = bits_nxt | mask;
          if (clr_r) bits_nxt = bits_nxt & (BYTE_ONES ^ mask);
        end
        res.port_touched = 1'b1;
      end
      R_SE: begin
        if (rx_byte == "t") begin
          set_nxt = 1'b1;
          clr_nxt = 1'b0;
        end
      end
      R_C1:  if (rx_byte == "l") state_nxt = R_C2;
      R_C2:  if (rx_byte == "e") state_nxt = R_C3;
      R_C3:  if (rx_byte == "a") state_nxt = R_C4;
      R_C4: begin
        if (rx_byte == "r") begin
          clr_nxt = 1'b1;
          set_nxt = 1'b0;
        end
      end
      R_U1:  if (rx_byte == "N") state_nxt = R_U2;
      R_U2:  if (rx_byte == "R") state_nxt = R_U3;
      R_U3:  if (rx_byte == "E") state_nxt = R_U4;
      R_U4:  if (rx_byte == "A") state_nxt = R_U5;
      R_U5: begin
        if (rx_byte == "D") begin
          pend_nxt = CODE_UNREAD;
          res.response_valid = 1'b1;
          res.response_code  = CODE_UNREAD;
          res.unread_seen    = 1'b1;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
    res.digital_out = bits_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/mrcp_number.sv @@
// Quoted phone number matcher: tracks the write position and reports stores.
// Depends on mrcp_pkg.
`default_nettype none
module mrcp_number
  import mrcp_pkg::*;
#(
  parameter int NUMBER_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output number_res_t     res
);

  localparam int IW = $clog2(NUMBER_LEN);
  localparam logic [IW-1:0] LAST = IW'(NUMBER_LEN - 1);

  number_state_t  state_r, state_nxt;
  logic [IW-1:0]  widx_r, widx_nxt;
  logic [31:0]    widx_ext;

  assign widx_ext = 32'(widx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      widx_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      widx_r  <= widx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    res       = '0;
    case (state_r)
      N_IDLE: begin
        if (rx_byte == CH_QUOTE) begin
          state_nxt = N_PLUS;
          widx_nxt  = '0;
        end
      end
      N_PLUS: begin
        if (rx_byte == "+") begin
          res.number_write = 1'b1;
          res.number_index = widx_ext[4:0];
          res.number_char  = rx_byte;
          if (widx_r < LAST) widx_nxt = widx_r + 1'b1;
          state_nxt = N_DIGITS;
        end else begin
          state_nxt = N_IDLE;
          widx_nxt  = '0;
        end
      end
      N_DIGITS: begin
        if (rx_byte >= "0" && rx_byte <= "9") begin
          if (widx_r < LAST) begin
            res.number_write = 1'b1;
            res.number_index = widx_ext[4:0];
            res.number_char  = rx_byte;
            widx_nxt = widx_r + 1'b1;
          end
        end else if (rx_byte == CH_QUOTE) begin
          res.number_write = 1'b1;
          res.number_index = widx_ext[4:0];
          res.number_done  = 1'b1;
          widx_nxt  = '0;
          state_nxt = N_IDLE;
        end else begin
          res.number_write   = 1'b1;
          res.number_cleared = 1'b1;
          widx_nxt  = '0;
          state_nxt = N_IDLE;
        end
      end
      default: begin
        res.number_write   = 1'b1;
        res.number_cleared = 1'b1;
        widx_nxt  = '0;
        state_nxt = N_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/modem_reply_and_command_parser.sv @@
// Modem reply and command parser, top level.
// Depends on mrcp_pkg, mrcp_if, mrcp_reply and mrcp_number.
//
// Usage:
//   in_ch carries one received modem byte (rx_byte) per item. out_ch carries
//   one result item per input item: reply events, the Status? pulse, the
//   eight remotely controlled output bits, the RD pulse, and the phone number
//   store write (position and character) with done and cleared flags.
//   The reply matcher and number matcher both see every byte.
// Latency and throughput:
//   A result appears on out_ch in the cycle after its byte is accepted. One item
//   is accepted every cycle while out_ch takes its results; the figure is set by
//   the single result register that follows the two matchers' next-state logic.
// Reset:
//   rst_n low (synchronous) returns both matchers to idle, clears the mode
//   flags, the output bits and the write position, and empties the result
//   register.
// Stall:
//   While out_ch is stalled with a result held, in_ch.ready is low; a new
//   byte is taken in the same cycle that the held result is taken.
`default_nettype none
module modem_reply_and_command_parser
  import mrcp_pkg::*;
#(
  parameter int NUMBER_LEN = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mrcp_in_if.sink    in_ch,
  mrcp_out_if.source out_ch
);

  logic        accept;
  logic        out_valid_r;
  reply_res_t  reply_res;
  number_res_t num_res;
  reply_res_t  reply_r;
  number_res_t num_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  mrcp_reply u_reply (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_byte (in_ch.rx_byte),
    .res     (reply_res)
  );

  mrcp_number #(
    .NUMBER_LEN (NUMBER_LEN)
  ) u_number (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_byte (in_ch.rx_byte),
    .res     (num_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reply_r <= reply_res;
      num_r   <= num_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.response_valid = reply_r.response_valid;
  assign out_ch.response_code  = reply_r.response_code;
  assign out_ch.status_request = reply_r.status_request;
  assign out_ch.digital_out    = reply_r.digital_out;
  assign out_ch.port_touched   = reply_r.port_touched;
  assign out_ch.unread_seen    = reply_r.unread_seen;
  assign out_ch.number_write   = num_r.number_write;
  assign out_ch.number_index   = num_r.number_index;
  assign out_ch.number_char    = num_r.number_char;
  assign out_ch.number_done    = num_r.number_done;
  assign out_ch.number_cleared = num_r.number_cleared;

endmodule
`default_nettype wire

@@ tb/sv/tb_modem_reply_and_command_parser.sv @@
// Testbench for modem_reply_and_command_parser: directed replies, commands and numbers, then
// random token traffic. A local byte-level predictor scores every result item in order.
// Depends on mrcp_pkg, mrcp_if and the parser RTL.
module tb_modem_reply_and_command_parser;
  import mrcp_pkg::*;

  localparam int NUM_LEN = 32;
  localparam int STALL_LIMIT = 2000;

  localparam int TOK_OK = 0;
  localparam int TOK_READY = 1;
  localparam int TOK_ERROR = 2;
  localparam int TOK_UNREAD = 3;
  localparam int TOK_STATUS = 4;
  localparam int TOK_SET = 5;
  localparam int TOK_CLEAR = 6;
  localparam int TOK_RD = 7;
  localparam int TOK_COUNT = 8;

  typedef struct packed {
    reply_res_t  rep;
    number_res_t num;
  } parse_res_t;

  logic clk = 1'b0;
  logic rst_n;

  mrcp_in_if  in_ch ();
  mrcp_out_if out_ch ();

  modem_reply_and_command_parser #(.NUMBER_LEN(NUM_LEN)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // predictor state
  reply_state_t  rs;
  resp_code_t    pend_code;
  logic          set_m;
  logic          clr_m;
  logic [7:0]    dout;
  number_state_t ns;
  logic [4:0]    widx;

  parse_res_t predicted_results[$];
  parse_res_t oldest;

  int sender_idle_pct;
  int recv_idle_pct;
  int sent_items;
  int errors;
  int stall_cycles;
  int n_replies, n_status, n_pins, n_done, n_cleared;

  function automatic void note_write(ref parse_res_t r, input logic [4:0] idx,
                                     input logic [7:0] ch);
    r.num.number_write = 1'b1;
    r.num.number_index = idx;
    r.num.number_char  = ch;
  endfunction

  function automatic parse_res_t parse_byte(input logic [7:0] b);
    parse_res_t r;
    logic [7:0] m;
    r = '0;
    case (rs)
      R_IDLE: begin
        pend_code = CODE_OK;
        case (b)
          "O": rs = R_O;
          ">": rs = R_GT;
          "E": rs = R_E1;
          "S": rs = R_S;
          "R": rs = R_R;
          "C": rs = R_C1;
          "U": rs = R_U1;
          default: rs = R_IDLE;
        endcase
      end
      R_O: begin
        if (b == "K") begin
          pend_code = CODE_OK;
          rs = R_CR;
        end else begin
          rs = R_IDLE;
        end
      end
      R_GT: begin
        if (b == " ") begin
          pend_code = CODE_READY;
          r.rep.response_valid = 1'b1;
          r.rep.response_code = CODE_READY;
        end
        rs = R_IDLE;
      end
      R_CR: rs = (b == CH_CR) ? R_LF : R_IDLE;
      R_LF: begin
        if (b == CH_LF) begin
          r.rep.response_valid = 1'b1;
          r.rep.response_code = pend_code;
        end
        rs = R_IDLE;
      end
      R_E1: rs = (b == "R") ? R_E2 : R_IDLE;
      R_E2: rs = (b == "R") ? R_E3 : R_IDLE;
      R_E3: rs = (b == "O") ? R_E4 : R_IDLE;
      R_E4: begin
        if (b == "R") begin
          pend_code = CODE_ERROR;
          r.rep.response_valid = 1'b1;
          r.rep.response_code = CODE_ERROR;
        end
        rs = R_IDLE;
      end
      R_S: begin
        if (b == "t") rs = R_ST1;
        else if (b == "e") rs = R_SE;
        else rs = R_IDLE;
      end
      R_ST1: rs = (b == "a") ? R_ST2 : R_IDLE;
      R_ST2: rs = (b == "t") ? R_ST3 : R_IDLE;
      R_ST3: rs = (b == "u") ? R_ST4 : R_IDLE;
      R_ST4: rs = (b == "s") ? R_ST5 : R_IDLE;
      R_ST5: begin
        if (b == "?") r.rep.status_request = 1'b1;
        rs = R_IDLE;
      end
      R_R: rs = (b == "D") ? R_RD : R_IDLE;
      R_RD: begin
        if (b >= "0" && b <= "7") begin
          m = 8'd1 << b[2:0];
          if (set_m) dout = dout | m;
          if (clr_m) dout = dout & (BYTE_ONES ^ m);
        end
        r.rep.port_touched = 1'b1;
        rs = R_IDLE;
      end
      R_SE: begin
        if (b == "t") begin
          set_m = 1'b1;
          clr_m = 1'b0;
        end
        rs = R_IDLE;
      end
      R_C1: rs = (b == "l") ? R_C2 : R_IDLE;
      R_C2: rs = (b == "e") ? R_C3 : R_IDLE;
      R_C3: rs = (b == "a") ? R_C4 : R_IDLE;
      R_C4: begin
        if (b == "r") begin
          clr_m = 1'b1;
          set_m = 1'b0;
        end
        rs = R_IDLE;
      end
      R_U1: rs = (b == "N") ? R_U2 : R_IDLE;
      R_U2: rs = (b == "R") ? R_U3 : R_IDLE;
      R_U3: rs = (b == "E") ? R_U4 : R_IDLE;
      R_U4: rs = (b == "A") ? R_U5 : R_IDLE;
      R_U5: begin
        if (b == "D") begin
          pend_code = CODE_UNREAD;
          r.rep.response_valid = 1'b1;
          r.rep.response_code = CODE_UNREAD;
          r.rep.unread_seen = 1'b1;
        end
        rs = R_IDLE;
      end
      default: rs = R_IDLE;
    endcase
    r.rep.digital_out = dout;

    case (ns)
      N_IDLE: begin
        if (b == CH_QUOTE) begin
          ns = N_PLUS;
          widx = '0;
        end
      end
      N_PLUS: begin
        if (b == "+") begin
          note_write(r, widx, b);
          if (widx < NUM_LEN - 1) widx = widx + 1'b1;
          ns = N_DIGITS;
        end else begin
          ns = N_IDLE;
          widx = '0;
        end
      end
      N_DIGITS: begin
        if (b >= "0" && b <= "9") begin
          // digits past the store's last free slot are dropped
          if (widx < NUM_LEN - 1) begin
            note_write(r, widx, b);
            widx = widx + 1'b1;
          end
        end else if (b == CH_QUOTE) begin
          note_write(r, widx, 8'd0);
          r.num.number_done = 1'b1;
          widx = '0;
          ns = N_IDLE;
        end else begin
          note_write(r, 5'd0, 8'd0);
          r.num.number_cleared = 1'b1;
          widx = '0;
          ns = N_IDLE;
        end
      end
      default: begin
        note_write(r, 5'd0, 8'd0);
        r.num.number_cleared = 1'b1;
        widx = '0;
        ns = N_IDLE;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predicted_results.push_back(parse_byte(in_ch.rx_byte));
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result item with nothing predicted", $time);
        errors++;
      end else begin
        oldest = predicted_results.pop_front();
        check_field("response_valid", oldest.rep.response_valid, out_ch.response_valid);
        check_field("response_code", oldest.rep.response_code, out_ch.response_code);
        check_field("status_request", oldest.rep.status_request, out_ch.status_request);
        check_field("digital_out", oldest.rep.digital_out, out_ch.digital_out);
        check_field("port_touched", oldest.rep.port_touched, out_ch.port_touched);
        check_field("unread_seen", oldest.rep.unread_seen, out_ch.unread_seen);
        check_field("number_write", oldest.num.number_write, out_ch.number_write);
        check_field("number_index", oldest.num.number_index, out_ch.number_index);
        check_field("number_char", oldest.num.number_char, out_ch.number_char);
        check_field("number_done", oldest.num.number_done, out_ch.number_done);
        check_field("number_cleared", oldest.num.number_cleared, out_ch.number_cleared);
        n_replies += oldest.rep.response_valid;
        n_status  += oldest.rep.status_request;
        n_pins    += oldest.rep.port_touched;
        n_done    += oldest.num.number_done;
        n_cleared += oldest.num.number_cleared;
      end
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ready is sampled at the falling edge, where nothing changes
  task automatic send_byte(input logic [7:0] b);
    bit hs;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do begin
      @(negedge clk);
      hs = in_ch.ready;
      @(posedge clk);
    end while (!hs);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  function automatic string token_text(input int k);
    case (k)
      TOK_OK:     return "OK";
      TOK_READY:  return "> ";
      TOK_ERROR:  return "ERROR";
      TOK_UNREAD: return "UNREAD";
      TOK_STATUS: return "Status?";
      TOK_SET:    return "Set";
      TOK_CLEAR:  return "Clear";
      default:    return "RD";
    endcase
  endfunction

  task automatic send_token(input int k);
    send_text(token_text(k));
    if (k == TOK_OK) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (k == TOK_RD) begin
      if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(8'("0" + $urandom_range(7)));
    end
  endtask

  task automatic send_number();
    int len;
    send_byte(CH_QUOTE);
    if ($urandom_range(9) == 0) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte("+");
      len = ($urandom_range(5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
      repeat (len) send_byte(8'("0" + $urandom_range(9)));
      if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(CH_QUOTE);
    end
  endtask

  task automatic send_random_token();
    int pick;
    string s;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 18) begin
      s = token_text($urandom_range(TOK_COUNT - 1));
      send_text(s.substr(0, $urandom_range(s.len() - 2)));
      send_byte(8'($urandom_range(255)));
    end else if (pick < 35) begin
      send_number();
    end else begin
      send_token($urandom_range(TOK_COUNT - 1));
    end
  endtask

  task automatic test_replies();
    send_token(TOK_OK);
    send_token(TOK_READY);
    send_token(TOK_ERROR);
    send_token(TOK_UNREAD);
  endtask

  // right after reset neither mode is on: pin commands must leave the bits alone
  task automatic test_pin_without_mode();
    send_text("RD0");
    send_text("RD");
    send_byte(BYTE_ONES);
  endtask

  task automatic test_number_cases();
    send_byte(CH_QUOTE);
    send_text("+5");
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte("+");
    send_byte(8'h00);
    send_byte(CH_QUOTE);
    send_byte("x");
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
    int target;
    sender_idle_pct = snd_pct;
    recv_idle_pct   = rcv_pct;
    target = sent_items + count;
    while (sent_items < target) send_random_token();
    wait_results_drained();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    sender_idle_pct = 24;
    recv_idle_pct   = 62;
    rs        = R_IDLE;
    pend_code = CODE_OK;
    set_m     = 1'b0;
    clr_m     = 1'b0;
    dout      = 8'h00;
    ns        = N_IDLE;
    widx      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pin_without_mode();
    test_replies();
    test_number_cases();
    wait_results_drained();

    test_random_traffic(24, 62, 320);
    test_random_traffic(62, 24, 320);
    test_random_traffic(0, 0, 310);
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes: %0d replies, %0d status requests, %0d pin commands.",
             sent_items, n_replies, n_status, n_pins);
    $display("Numbers completed %0d, discarded %0d, final output bits %02h.",
             n_done, n_cleared, dout);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
